FILE: sv/rv64ex_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RV64I register-operation execute block.
// No dependencies; every other file of the block refers to it by scoped names.

package rv64ex_pkg;

    typedef enum logic [4:0] {
        CMD_ADD   = 5'd0,
        CMD_ADDI  = 5'd1,
        CMD_SUB   = 5'd2,
        CMD_OR    = 5'd3,
        CMD_ORI   = 5'd4,
        CMD_AND   = 5'd5,
        CMD_ANDI  = 5'd6,
        CMD_XOR   = 5'd7,
        CMD_XORI  = 5'd8,
        CMD_SLL   = 5'd9,
        CMD_SLLI  = 5'd10,
        CMD_SRL   = 5'd11,
        CMD_SRLI  = 5'd12,
        CMD_SRA   = 5'd13,
        CMD_SRAI  = 5'd14,
        CMD_ADDW  = 5'd15,
        CMD_ADDIW = 5'd16,
        CMD_SUBW  = 5'd17,
        CMD_SLLW  = 5'd18,
        CMD_SLLIW = 5'd19,
        CMD_SRLW  = 5'd20,
        CMD_SRLIW = 5'd21,
        CMD_SRAW  = 5'd22,
        CMD_SRAIW = 5'd23,
        CMD_LUI   = 5'd24,
        CMD_ECALL = 5'd25,
        CMD_OTHER = 5'd26
    } cmd_t;

    typedef enum logic [2:0] {
        ST_DONE        = 3'd0,
        ST_SYS_RETURN  = 3'd1,
        ST_UNSUPPORTED = 3'd2,
        ST_OUT_WINDOW  = 3'd3,
        ST_EXIT        = 3'd4,
        ST_UNKNOWN_SYS = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CFG_START_PC    = 2'd0,
        CFG_WINDOW_LOW  = 2'd1,
        CFG_WINDOW_HIGH = 2'd2
    } cfg_idx_t;

    localparam int         XLEN        = 64;
    localparam int         REG_AW      = 5;
    localparam int         IMM_W       = 20;
    localparam logic [4:0] SYSCALL_REG = 5'd17;
    localparam logic [63:0] SYS_RETURN = 64'd23;
    localparam logic [63:0] SYS_EXIT   = 64'd2;
    localparam logic [63:0] PC_STEP    = 64'd4;

endpackage

FILE: sv/rv64ex_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for instruction beats and result beats.
// Depends on rv64ex_pkg for the immediate field width.

interface rv64ex_instr_if;
    logic       valid;
    logic       ready;
    logic [4:0] cmd;
    logic [4:0] dest_reg;
    logic [4:0] src_reg_a;
    logic [4:0] src_reg_b;
    logic signed [rv64ex_pkg::IMM_W-1:0] immediate;

    modport source (output valid, cmd, dest_reg, src_reg_a, src_reg_b, immediate,
                    input ready);
    modport sink   (input valid, cmd, dest_reg, src_reg_a, src_reg_b, immediate,
                    output ready);
endinterface

interface rv64ex_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] next_pc;
    logic        write_enable;
    logic [63:0] write_value;

    modport source (output valid, status, next_pc, write_enable, write_value,
                    input ready);
    modport sink   (input valid, status, next_pc, write_enable, write_value,
                     output ready);
endinterface

FILE: sv/rv64i_register_op_execute.sv
`timescale 1ns / 1ps
// Throughput: one instruction per cycle while the result channel is not stalled by result.ready;
// the register file's synchronous read is registered alongside the execute stage, and a
// write-to-read bypass covers back-to-back dependencies. Reset clears all registers to zero
// through per-entry valid bits, loads the program counter with zero and opens the instruction
// window from address zero up to the all-ones address, which as the exclusive bound lies outside.
// Depends on rv64ex_pkg and rv64ex_if.

module rv64i_register_op_execute (
    input  logic                 clk,
    input  logic                 rst_n,
    rv64ex_instr_if.sink         instr,
    rv64ex_result_if.source      result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    localparam int DEPTH = 1 << rv64ex_pkg::REG_AW;

    // Configuration registers and program counter.
    logic [63:0] start_pc_reg;
    logic [63:0] window_low_reg;
    logic [63:0] window_high_reg;
    logic [63:0] pc_reg;
    logic [63:0] pc_next;

    // Two copies of the register file, one per read port.
    logic [63:0] rf_a_mem [DEPTH];
    logic [63:0] rf_b_mem [DEPTH];
    logic [DEPTH-1:0] rf_valid_reg;

    logic [63:0] rdata_a_reg;
    logic [63:0] rdata_b_reg;
    logic        live_a_reg;
    logic        live_b_reg;

    // Execute stage.
    logic                    s1_valid_reg;
    rv64ex_pkg::cmd_t        s1_cmd_reg;
    logic [4:0]              s1_rd_reg;
    logic [4:0]              s1_addr_a_reg;
    logic [4:0]              s1_addr_b_reg;
    logic [19:0]             s1_imm_reg;

    // Bypass of the write that coincided with the operand read.
    logic        fwd_en_reg;
    logic [4:0]  fwd_addr_reg;
    logic [63:0] fwd_data_reg;

    // Output register.
    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [63:0] out_pc_reg;
    logic        out_we_reg;
    logic [63:0] out_value_reg;

    logic in_fire;
    logic s1_fire;
    logic cfg_write;
    logic [4:0] rd_addr_a;

    logic [63:0] op_a;
    logic [63:0] op_b;
    logic [63:0] imm64;
    logic [63:0] alu_r;
    logic [31:0] w32;
    logic [5:0]  sh_b;
    logic [5:0]  sh_i;
    rv64ex_pkg::status_t status_next;
    logic        alu_op;
    logic        wr_en;
    logic        in_window;

    function automatic logic [63:0] sext32(input logic [31:0] v);
        sext32 = {{32{v[31]}}, v};
    endfunction

    assign s1_fire     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign instr.ready = !s1_valid_reg || s1_fire;
    assign in_fire     = instr.valid && instr.ready;
    assign cfg_write   = psel && penable && pwrite && pready;
    assign pready      = 1'b1;

    assign rd_addr_a = (rv64ex_pkg::cmd_t'(instr.cmd) == rv64ex_pkg::CMD_ECALL)
                       ? rv64ex_pkg::SYSCALL_REG : instr.src_reg_a;

    always_comb
    begin
        case (rv64ex_pkg::cfg_idx_t'(paddr[4:3]))
            rv64ex_pkg::CFG_START_PC:    prdata = start_pc_reg;
            rv64ex_pkg::CFG_WINDOW_LOW:  prdata = window_low_reg;
            rv64ex_pkg::CFG_WINDOW_HIGH: prdata = window_high_reg;
            default:                     prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_reg    <= 64'd0;
            window_low_reg  <= 64'd0;
            window_high_reg <= '1;
        end
        else if (cfg_write)
        begin
            case (rv64ex_pkg::cfg_idx_t'(paddr[4:3]))
                rv64ex_pkg::CFG_START_PC:    start_pc_reg    <= pwdata;
                rv64ex_pkg::CFG_WINDOW_LOW:  window_low_reg  <= pwdata;
                rv64ex_pkg::CFG_WINDOW_HIGH: window_high_reg <= pwdata;
                default:                     ;
            endcase
        end
    end

    // Operand memories: synchronous read issued when an instruction beat is taken.
    always_ff @(posedge clk)
    begin
        if (wr_en && s1_fire)
        begin
            rf_a_mem[s1_rd_reg] <= alu_r;
            rf_b_mem[s1_rd_reg] <= alu_r;
        end
        if (in_fire)
        begin
            rdata_a_reg <= rf_a_mem[rd_addr_a];
            rdata_b_reg <= rf_b_mem[instr.src_reg_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
            live_a_reg   <= 1'b0;
            live_b_reg   <= 1'b0;
            fwd_en_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en && s1_fire)
            begin
                rf_valid_reg[s1_rd_reg] <= 1'b1;
            end
            if (in_fire)
            begin
                live_a_reg <= rf_valid_reg[rd_addr_a];
                live_b_reg <= rf_valid_reg[instr.src_reg_b];
                fwd_en_reg <= wr_en && s1_fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            fwd_addr_reg  <= s1_rd_reg;
            fwd_data_reg  <= alu_r;
            s1_cmd_reg    <= rv64ex_pkg::cmd_t'(instr.cmd);
            s1_rd_reg     <= instr.dest_reg;
            s1_addr_a_reg <= rd_addr_a;
            s1_addr_b_reg <= instr.src_reg_b;
            s1_imm_reg    <= instr.immediate;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        op_a = live_a_reg ? rdata_a_reg : 64'd0;
        if (fwd_en_reg && fwd_addr_reg == s1_addr_a_reg)
        begin
            op_a = fwd_data_reg;
        end
        op_b = live_b_reg ? rdata_b_reg : 64'd0;
        if (fwd_en_reg && fwd_addr_reg == s1_addr_b_reg)
        begin
            op_b = fwd_data_reg;
        end
    end

    assign imm64 = {{44{s1_imm_reg[19]}}, s1_imm_reg};
    assign sh_b  = op_b[5:0];
    assign sh_i  = s1_imm_reg[5:0];

    always_comb
    begin
        alu_r = 64'd0;
        w32   = 32'd0;
        case (s1_cmd_reg)
            rv64ex_pkg::CMD_ADD:   alu_r = op_a + op_b;
            rv64ex_pkg::CMD_ADDI:  alu_r = op_a + imm64;
            rv64ex_pkg::CMD_SUB:   alu_r = op_a - op_b;
            rv64ex_pkg::CMD_OR:    alu_r = op_a | op_b;
            rv64ex_pkg::CMD_ORI:   alu_r = op_a | imm64;
            rv64ex_pkg::CMD_AND:   alu_r = op_a & op_b;
            rv64ex_pkg::CMD_ANDI:  alu_r = op_a & imm64;
            rv64ex_pkg::CMD_XOR:   alu_r = op_a ^ op_b;
            rv64ex_pkg::CMD_XORI:  alu_r = op_a ^ imm64;
            rv64ex_pkg::CMD_SLL:   alu_r = op_a << sh_b;
            rv64ex_pkg::CMD_SLLI:  alu_r = op_a << sh_i;
            rv64ex_pkg::CMD_SRL:   alu_r = op_a >> sh_b;
            rv64ex_pkg::CMD_SRLI:  alu_r = op_a >> sh_i;
            rv64ex_pkg::CMD_SRA:   alu_r = 64'($signed(op_a) >>> sh_b);
            rv64ex_pkg::CMD_SRAI:  alu_r = 64'($signed(op_a) >>> sh_i);
            rv64ex_pkg::CMD_ADDW:
            begin
                w32   = op_a[31:0] + op_b[31:0];
                alu_r = sext32(w32);
            end
            rv64ex_pkg::CMD_ADDIW:
            begin
                w32   = op_a[31:0] + imm64[31:0];
                alu_r = sext32(w32);
            end
            rv64ex_pkg::CMD_SUBW:
            begin
                w32   = op_a[31:0] - op_b[31:0];
                alu_r = sext32(w32);
            end
            rv64ex_pkg::CMD_SLLW:
            begin
                w32   = op_a[31:0] << sh_b[4:0];
                alu_r = sext32(w32);
            end
            rv64ex_pkg::CMD_SLLIW:
            begin
                w32   = op_a[31:0] << sh_i[4:0];
                alu_r = sext32(w32);
            end
            rv64ex_pkg::CMD_SRLW:
            begin
                w32   = op_a[31:0] >> sh_b[4:0];
                alu_r = sext32(w32);
            end
            rv64ex_pkg::CMD_SRLIW:
            begin
                w32   = op_a[31:0] >> sh_i[4:0];
                alu_r = sext32(w32);
            end
            rv64ex_pkg::CMD_SRAW:
            begin
                w32   = 32'($signed(op_a[31:0]) >>> sh_b[4:0]);
                alu_r = sext32(w32);
            end
            rv64ex_pkg::CMD_SRAIW:
            begin
                w32   = 32'($signed(op_a[31:0]) >>> sh_i[4:0]);
                alu_r = sext32(w32);
            end
            rv64ex_pkg::CMD_LUI:   alu_r = {{32{s1_imm_reg[19]}}, s1_imm_reg, 12'd0};
            default:               alu_r = 64'd0;
        endcase
    end

    assign in_window = (pc_reg >= window_low_reg) && (pc_reg < window_high_reg);
    assign alu_op    = (5'(s1_cmd_reg) <= 5'(rv64ex_pkg::CMD_LUI));

    always_comb
    begin
        status_next = rv64ex_pkg::ST_DONE;
        wr_en       = 1'b0;
        pc_next     = pc_reg;
        if (!in_window)
        begin
            status_next = rv64ex_pkg::ST_OUT_WINDOW;
        end
        else if (alu_op)
        begin
            wr_en   = (s1_rd_reg != 5'd0);
            pc_next = pc_reg + rv64ex_pkg::PC_STEP;
        end
        else if (s1_cmd_reg == rv64ex_pkg::CMD_ECALL)
        begin
            if (op_a == rv64ex_pkg::SYS_RETURN)
            begin
                status_next = rv64ex_pkg::ST_SYS_RETURN;
                pc_next     = pc_reg + rv64ex_pkg::PC_STEP;
            end
            else if (op_a == rv64ex_pkg::SYS_EXIT)
            begin
                status_next = rv64ex_pkg::ST_EXIT;
            end
            else
            begin
                status_next = rv64ex_pkg::ST_UNKNOWN_SYS;
            end
        end
        else
        begin
            status_next = rv64ex_pkg::ST_UNSUPPORTED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= 64'd0;
        end
        else if (cfg_write && rv64ex_pkg::cfg_idx_t'(paddr[4:3]) == rv64ex_pkg::CFG_START_PC)
        begin
            pc_reg <= pwdata;
        end
        else if (s1_fire)
        begin
            pc_reg <= pc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_status_reg <= status_next;
            out_pc_reg     <= pc_next;
            out_we_reg     <= wr_en;
            out_value_reg  <= wr_en ? alu_r : 64'd0;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.next_pc      = out_pc_reg;
    assign result.write_enable = out_we_reg;
    assign result.write_value  = out_value_reg;

    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && wr_en) |-> (s1_rd_reg != 5'd0))
        else $error("register x0 written");

    a_x0_never_live: assert property (@(posedge clk) disable iff (!rst_n)
        !rf_valid_reg[0])
        else $error("register x0 marked as written");

    a_stage_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("executed instruction produced no result beat");

    a_window_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == rv64ex_pkg::ST_OUT_WINDOW) |-> !out_we_reg)
        else $error("write reported for an instruction outside the window");

    a_fault_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && status_next == rv64ex_pkg::ST_UNSUPPORTED) |=> (pc_reg == $past(pc_reg)))
        else $error("program counter moved on an unsupported operation");

endmodule

FILE: sim/tb_rv64i_register_op_execute.sv
`timescale 1ns / 1ps
// Self-checking testbench for rv64i_register_op_execute: sends instruction beats and APB
// register writes, predicts every result beat from its own register-file model and compares.
// Depends on rv64ex_pkg, rv64ex_if and the block itself.

module tb_rv64i_register_op_execute;

    typedef struct {
        rv64ex_pkg::status_t status;
        logic [63:0]         next_pc;
        logic                wr_en;
        logic [63:0]         wr_val;
    } exec_result_t;

    localparam logic [4:0]  OP_CODE_MAX = 5'h1F;
    localparam logic [4:0]  ZERO_REG    = 5'd0;
    localparam logic [63:0] ALL_ONES    = '1;
    localparam logic [63:0] TOP_WORD_PC = 64'hFFFF_FFFF_FFFF_FFFC;
    localparam logic [19:0] IMM_RETURN  = 20'(rv64ex_pkg::SYS_RETURN);
    localparam logic [19:0] IMM_EXIT    = 20'(rv64ex_pkg::SYS_EXIT);

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    rv64ex_instr_if  instr ();
    rv64ex_result_if result ();

    rv64i_register_op_execute dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .instr   (instr),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [63:0]  gpr [32];
    logic [63:0]  model_pc;
    logic [63:0]  win_lo;
    logic [63:0]  win_hi;
    exec_result_t pending_q [$];
    int           err_cnt    = 0;
    bit           no_idle    = 1'b0;
    int           stall_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] sext_word(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    task automatic predict_result(input logic [4:0] op, rd, ra, rb, input logic [19:0] imm);
        logic [63:0]         a;
        logic [63:0]         b;
        logic [63:0]         immx;
        logic [63:0]         pc_now;
        logic [63:0]         res;
        rv64ex_pkg::status_t st;
        logic                wr;
        exec_result_t        beat;
        a      = gpr[ra];
        b      = gpr[rb];
        immx   = {{44{imm[19]}}, imm};
        pc_now = model_pc;
        res    = '0;
        st     = rv64ex_pkg::ST_DONE;
        wr     = 1'b0;
        if (pc_now < win_lo || pc_now >= win_hi)
        begin
            st = rv64ex_pkg::ST_OUT_WINDOW;
        end
        else
        begin
            case (op)
                rv64ex_pkg::CMD_ADD:   res = a + b;
                rv64ex_pkg::CMD_ADDI:  res = a + immx;
                rv64ex_pkg::CMD_SUB:   res = a - b;
                rv64ex_pkg::CMD_OR:    res = a | b;
                rv64ex_pkg::CMD_ORI:   res = a | immx;
                rv64ex_pkg::CMD_AND:   res = a & b;
                rv64ex_pkg::CMD_ANDI:  res = a & immx;
                rv64ex_pkg::CMD_XOR:   res = a ^ b;
                rv64ex_pkg::CMD_XORI:  res = a ^ immx;
                rv64ex_pkg::CMD_SLL:   res = a << b[5:0];
                rv64ex_pkg::CMD_SLLI:  res = a << immx[5:0];
                rv64ex_pkg::CMD_SRL:   res = a >> b[5:0];
                rv64ex_pkg::CMD_SRLI:  res = a >> immx[5:0];
                rv64ex_pkg::CMD_SRA:   res = $signed(a) >>> b[5:0];
                rv64ex_pkg::CMD_SRAI:  res = $signed(a) >>> immx[5:0];
                rv64ex_pkg::CMD_ADDW:  res = sext_word(a + b);
                rv64ex_pkg::CMD_ADDIW: res = sext_word(a + immx);
                rv64ex_pkg::CMD_SUBW:  res = sext_word(a - b);
                rv64ex_pkg::CMD_SLLW:  res = sext_word(a << b[4:0]);
                rv64ex_pkg::CMD_SLLIW: res = sext_word(a << immx[4:0]);
                rv64ex_pkg::CMD_SRLW:  res = sext_word({32'b0, a[31:0]} >> b[4:0]);
                rv64ex_pkg::CMD_SRLIW: res = sext_word({32'b0, a[31:0]} >> immx[4:0]);
                rv64ex_pkg::CMD_SRAW:  res = $signed(sext_word(a)) >>> b[4:0];
                rv64ex_pkg::CMD_SRAIW: res = $signed(sext_word(a)) >>> immx[4:0];
                rv64ex_pkg::CMD_LUI:   res = sext_word(immx << 12);
                rv64ex_pkg::CMD_ECALL:
                begin
                    if (gpr[rv64ex_pkg::SYSCALL_REG] == rv64ex_pkg::SYS_RETURN)
                        st = rv64ex_pkg::ST_SYS_RETURN;
                    else if (gpr[rv64ex_pkg::SYSCALL_REG] == rv64ex_pkg::SYS_EXIT)
                        st = rv64ex_pkg::ST_EXIT;
                    else
                        st = rv64ex_pkg::ST_UNKNOWN_SYS;
                end
                default:   st = rv64ex_pkg::ST_UNSUPPORTED;
            endcase
            if (op <= rv64ex_pkg::CMD_LUI)
            begin
                if (rd != ZERO_REG)
                begin
                    gpr[rd] = res;
                    wr      = 1'b1;
                end
                model_pc = pc_now + rv64ex_pkg::PC_STEP;
            end
            else if (st == rv64ex_pkg::ST_SYS_RETURN)
            begin
                model_pc = pc_now + rv64ex_pkg::PC_STEP;
            end
        end
        beat.status  = st;
        beat.next_pc = model_pc;
        beat.wr_en   = wr;
        beat.wr_val  = wr ? res : 64'd0;
        pending_q.push_back(beat);
    endtask

    task automatic send_op(input logic [4:0] op, rd, ra, rb, input logic [19:0] imm);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            instr.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        instr.valid     <= 1'b1;
        instr.cmd       <= op;
        instr.dest_reg  <= rd;
        instr.src_reg_a <= ra;
        instr.src_reg_b <= rb;
        instr.immediate <= imm;
        do @(posedge clk); while (instr.ready !== 1'b1);
        predict_result(op, rd, ra, rb, imm);
    endtask

    task automatic drain_results();
        instr.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input rv64ex_pkg::cfg_idx_t idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
    endtask

    // Writing the start address also reloads the program counter.
    task automatic program_regs(input logic [63:0] start_val, lo, hi);
        drain_results();
        apb_write(rv64ex_pkg::CFG_START_PC, start_val);
        apb_write(rv64ex_pkg::CFG_WINDOW_LOW, lo);
        apb_write(rv64ex_pkg::CFG_WINDOW_HIGH, hi);
        psel    <= 1'b0;
        penable <= 1'b0;
        model_pc = start_val;
        win_lo   = lo;
        win_hi   = hi;
    endtask

    task automatic send_random_op();
        int          kind;
        logic [4:0]  rd;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [19:0] imm;
        kind = $urandom_range(0, 99);
        rd   = 5'($urandom_range(0, 31));
        ra   = 5'($urandom_range(0, 31));
        rb   = 5'($urandom_range(0, 31));
        imm  = 20'($urandom);
        if (kind < 72)
        begin
            send_op(5'($urandom_range(rv64ex_pkg::CMD_ADD, rv64ex_pkg::CMD_LUI)),
                    rd, ra, rb, imm);
        end
        else if (kind < 80)
        begin
            case ($urandom_range(0, 2))
                0:       imm = IMM_RETURN;
                1:       imm = IMM_EXIT;
                default: imm = 20'($urandom_range(0, 40));
            endcase
            send_op(rv64ex_pkg::CMD_ADDI, rv64ex_pkg::SYSCALL_REG, ZERO_REG, rb, imm);
        end
        else if (kind < 90)
        begin
            send_op(rv64ex_pkg::CMD_ECALL, rd, ra, rb, imm);
        end
        else if (kind < 95)
        begin
            send_op(5'($urandom_range(rv64ex_pkg::CMD_OTHER, OP_CODE_MAX)), rd, ra, rb, imm);
        end
        else
        begin
            send_op(rv64ex_pkg::CMD_LUI, rd, ra, rb, imm);
        end
        if ($urandom_range(0, 99) == 0)
            drain_results();
    endtask

    task automatic test_alu_directed();
        send_op(rv64ex_pkg::CMD_LUI,   1, 0, 0, 20'h80000);
        send_op(rv64ex_pkg::CMD_ADDI,  2, 0, 0, 20'h7FFFF);
        send_op(rv64ex_pkg::CMD_ADDI,  3, 0, 0, 20'h80000);
        send_op(rv64ex_pkg::CMD_LUI,   4, 0, 0, 20'h7FFFF);
        send_op(rv64ex_pkg::CMD_ADD,   5, 1, 4, 20'h0);
        send_op(rv64ex_pkg::CMD_SUB,   6, 4, 1, 20'h0);
        send_op(rv64ex_pkg::CMD_OR,    7, 1, 2, 20'h0);
        send_op(rv64ex_pkg::CMD_ORI,   8, 3, 0, 20'h00555);
        send_op(rv64ex_pkg::CMD_AND,   9, 1, 3, 20'h0);
        send_op(rv64ex_pkg::CMD_ANDI, 10, 1, 0, 20'hFFFFF);
        send_op(rv64ex_pkg::CMD_XOR,  11, 1, 4, 20'h0);
        send_op(rv64ex_pkg::CMD_XORI, 12, 3, 0, 20'hFFFFF);
        send_op(rv64ex_pkg::CMD_SLL,  13, 2, 2, 20'h0);
        send_op(rv64ex_pkg::CMD_SLLI, 14, 1, 0, 20'h0007F);
        send_op(rv64ex_pkg::CMD_SRL,  15, 1, 2, 20'h0);
        send_op(rv64ex_pkg::CMD_SRLI, 16, 1, 0, 20'h0);
        send_op(rv64ex_pkg::CMD_SRA,  18, 1, 2, 20'h0);
        send_op(rv64ex_pkg::CMD_SRAI, 19, 1, 0, 20'h00020);
        send_op(rv64ex_pkg::CMD_ADDW, 20, 4, 4, 20'h0);
        send_op(rv64ex_pkg::CMD_ADDIW, 21, 4, 0, 20'h7FFFF);
        send_op(rv64ex_pkg::CMD_SUBW, 22, 1, 2, 20'h0);
        send_op(rv64ex_pkg::CMD_SLLW, 23, 2, 2, 20'h0);
        send_op(rv64ex_pkg::CMD_SLLIW, 24, 2, 0, 20'hFFFFF);
        send_op(rv64ex_pkg::CMD_SRLW, 25, 1, 2, 20'h0);
        send_op(rv64ex_pkg::CMD_SRLIW, 26, 1, 0, 20'h0);
        send_op(rv64ex_pkg::CMD_SRAW, 27, 1, 2, 20'h0);
        send_op(rv64ex_pkg::CMD_SRAIW, 28, 4, 0, 20'h00004);
        send_op(rv64ex_pkg::CMD_ADD,  ZERO_REG, 1, 4, 20'h0);
    endtask

    task automatic test_ecall_and_unsupported();
        send_op(rv64ex_pkg::CMD_ECALL, 0, 0, 0, 20'h0);
        send_op(rv64ex_pkg::CMD_ADDI, rv64ex_pkg::SYSCALL_REG, ZERO_REG, 0, IMM_RETURN);
        send_op(rv64ex_pkg::CMD_ECALL, 0, 0, 0, 20'h0);
        send_op(rv64ex_pkg::CMD_ADDI, rv64ex_pkg::SYSCALL_REG, ZERO_REG, 0, IMM_EXIT);
        send_op(rv64ex_pkg::CMD_ECALL, 0, 0, 0, 20'h0);
        send_op(rv64ex_pkg::CMD_OTHER, 5, 1, 2, 20'h0);
        send_op(OP_CODE_MAX, 6, 1, 2, 20'hFFFFF);
    endtask

    task automatic test_pc_window();
        program_regs(TOP_WORD_PC - rv64ex_pkg::PC_STEP, 64'd0, ALL_ONES);
        repeat (3) send_op(rv64ex_pkg::CMD_ADDI, 5, 5, 0, 20'h00001);
        program_regs(ALL_ONES, 64'd0, ALL_ONES);
        send_op(rv64ex_pkg::CMD_ADDI, 5, 5, 0, 20'h00001);
        program_regs(64'h1000, 64'h1000, 64'h1008);
        repeat (3) send_op(rv64ex_pkg::CMD_ADDI, 6, 6, 0, 20'h00003);
        program_regs(64'h0FFC, 64'h1000, ALL_ONES);
        send_op(rv64ex_pkg::CMD_ADDI, 7, 7, 0, 20'h00001);
        program_regs(64'd0, ALL_ONES, 64'd0);
        send_op(rv64ex_pkg::CMD_ADDI, 7, 7, 0, 20'h00001);
    endtask

    task automatic test_random_ops();
        logic [63:0] base;
        logic [63:0] lo;
        logic [63:0] hi;
        for (int ph = 0; ph < 5; ph++)
        begin
            base = {$urandom, $urandom};
            case (ph)
                0: program_regs(base, 64'd0, ALL_ONES);
                1:
                begin
                    base = base & 64'h7FFF_FFFF_FFFF_FFF0;
                    program_regs(base, base,
                                 base + rv64ex_pkg::PC_STEP * $urandom_range(100, 200));
                end
                2:
                begin
                    no_idle = 1'b1;
                    program_regs(TOP_WORD_PC - rv64ex_pkg::PC_STEP * $urandom_range(10, 60),
                                 64'd0, ALL_ONES);
                end
                3:
                begin
                    lo = base - rv64ex_pkg::PC_STEP * $urandom_range(0, 3);
                    hi = base + rv64ex_pkg::PC_STEP * $urandom_range(0, 300);
                    program_regs(base, lo, hi);
                end
                default: program_regs(64'd0, 64'd0, ALL_ONES);
            endcase
            repeat (230) send_random_op();
            drain_results();
            no_idle = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
        end
        else if (stall_left > 0 && !no_idle)
        begin
            result.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            result.ready <= 1'b1;
            stall_left = no_idle ? 0 : pick_gap();
        end
    end

    always @(posedge clk)
    begin : result_check
        exec_result_t want;
        if (rst_n && result.valid === 1'b1 && result.ready === 1'b1)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result beat arrived with no instruction outstanding");
                err_cnt++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, result.status);
                    err_cnt++;
                end
                if (result.next_pc !== want.next_pc)
                begin
                    $error("next_pc mismatch: expected %h, actual %h",
                           want.next_pc, result.next_pc);
                    err_cnt++;
                end
                if (result.write_enable !== want.wr_en)
                begin
                    $error("write_enable mismatch: expected %0d, actual %0d",
                           want.wr_en, result.write_enable);
                    err_cnt++;
                end
                if (result.write_value !== want.wr_val)
                begin
                    $error("write_value mismatch: expected %h, actual %h",
                           want.wr_val, result.write_value);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        instr.valid     <= 1'b0;
        instr.cmd       <= rv64ex_pkg::CMD_ADD;
        instr.dest_reg  <= '0;
        instr.src_reg_a <= '0;
        instr.src_reg_b <= '0;
        instr.immediate <= '0;
        for (int i = 0; i < 32; i++)
            gpr[i] = '0;
        model_pc = '0;
        win_lo   = '0;
        win_hi   = ALL_ONES;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_alu_directed();
        test_ecall_and_unsupported();
        test_pc_window();
        test_random_ops();
        drain_results();
        repeat (6) @(posedge clk);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #(64'd8_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
sv/rv64ex_pkg.sv
sv/rv64ex_if.sv
sv/rv64i_register_op_execute.sv
sim/tb_rv64i_register_op_execute.sv
